// File: hw/rtl/ckct_pkg.sv
// Shared types, constants and helpers of the color-key centroid tracker.
// No dependencies; every other file of the block but ckct_queue imports it.
package ckct_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int COUNT_BITS     = 22;
  localparam int LEVEL_BITS     = 8;
  localparam int DIM_BITS       = 12;
  localparam int PADDR_BITS     = 5;
  localparam int PDATA_BITS     = 32;
  localparam int JOB_DEPTH      = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [LEVEL_BITS-1:0] RESET_REF_BLUE     = 8'd65;
  localparam logic [LEVEL_BITS-1:0] RESET_REF_GREEN    = 8'd70;
  localparam logic [LEVEL_BITS-1:0] RESET_REF_RED      = 8'd170;
  localparam logic [LEVEL_BITS-1:0] RESET_TOLERANCE    = 8'd30;
  localparam logic [DIM_BITS-1:0]   RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [DIM_BITS-1:0]   RESET_FRAME_HEIGHT = 12'd480;
  // reference level of the grey marker variant
  localparam logic [LEVEL_BITS-1:0] GREY_REF_LEVEL     = 8'd150;

  typedef enum logic [2:0] {
    REG_REF_BLUE     = 3'd0,
    REG_REF_GREEN    = 3'd1,
    REG_REF_RED      = 3'd2,
    REG_TOLERANCE    = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] ref_blue;
    logic [LEVEL_BITS-1:0] ref_green;
    logic [LEVEL_BITS-1:0] ref_red;
    logic [LEVEL_BITS-1:0] tolerance;
    logic [DIM_BITS-1:0]   frame_width;
    logic [DIM_BITS-1:0]   frame_height;
  } cfg_t;

  function automatic logic chan_close(input logic [LEVEL_BITS-1:0] level,
                                      input logic [LEVEL_BITS-1:0] ref_level,
                                      input logic [LEVEL_BITS-1:0] tol);
    logic [LEVEL_BITS-1:0] diff;
    diff = (level >= ref_level) ? (level - ref_level) : (ref_level - level);
    return diff < tol;
  endfunction

endpackage

// File: hw/rtl/color_key_centroid_tracker.sv
// Top level of the color-key centroid tracker: register port, pixel front,
// frame job queue and divider back. Depends on ckct_pkg and the ckct modules.
//
//   channel   direction  handshake              beat
//   pixel     in         push / full            pixel_x pixel_y blue green red frame_end
//   result    out        pop / empty            centroid_x centroid_y match_count empty_frame
//   config    in         psel penable pwrite    paddr pwdata -> prdata, pready tied high
//
// Pixels: one beat per cycle while full is low; the front adds each match in the cycle it arrives.
// A job leaving the queue runs the divider loop, which retires one quotient bit of
// both centroids a cycle; the result then waits until the result register is free.
// full rises while two frame jobs wait for the divider; all pixels stall then.
// Reset clears the sums, empties the job queue, idles the divider, empties the result
// register, and loads register defaults.
module color_key_centroid_tracker #(
  parameter int COORD_BITS = ckct_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [COORD_BITS-1:0]           pixel_x,
  input  logic [COORD_BITS-1:0]           pixel_y,
  input  logic [7:0]                      blue,
  input  logic [7:0]                      green,
  input  logic [7:0]                      red,
  input  logic                            frame_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [COORD_BITS-1:0]           centroid_x,
  output logic [COORD_BITS-1:0]           centroid_y,
  output logic [ckct_pkg::COUNT_BITS-1:0] match_count,
  output logic                            empty_frame,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ckct_pkg::PADDR_BITS-1:0] paddr,
  input  logic [ckct_pkg::PDATA_BITS-1:0] pwdata,
  output logic [ckct_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready
);
  import ckct_pkg::*;

  localparam int SUM_BITS = COUNT_BITS + COORD_BITS;
  localparam int JOB_BITS = COUNT_BITS + 2 * SUM_BITS;

  cfg_t                cfg;
  reg_index_t          reg_index;
  logic                cfg_write;
  logic                accept;
  logic                job_valid;
  logic [JOB_BITS-1:0] job_wr_data;
  logic [JOB_BITS-1:0] job_rd_data;
  logic                job_pop;
  logic                job_empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = reg_index_t'(paddr[PADDR_BITS-1:2]);
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_blue     <= RESET_REF_BLUE;
      cfg.ref_green    <= RESET_REF_GREEN;
      cfg.ref_red      <= RESET_REF_RED;
      cfg.tolerance    <= RESET_TOLERANCE;
      cfg.frame_width  <= RESET_FRAME_WIDTH;
      cfg.frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_REF_BLUE:     cfg.ref_blue     <= pwdata[LEVEL_BITS-1:0];
        REG_REF_GREEN:    cfg.ref_green    <= pwdata[LEVEL_BITS-1:0];
        REG_REF_RED:      cfg.ref_red      <= pwdata[LEVEL_BITS-1:0];
        REG_TOLERANCE:    cfg.tolerance    <= pwdata[LEVEL_BITS-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_REF_BLUE:     prdata = PDATA_BITS'(cfg.ref_blue);
      REG_REF_GREEN:    prdata = PDATA_BITS'(cfg.ref_green);
      REG_REF_RED:      prdata = PDATA_BITS'(cfg.ref_red);
      REG_TOLERANCE:    prdata = PDATA_BITS'(cfg.tolerance);
      REG_FRAME_WIDTH:  prdata = PDATA_BITS'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = PDATA_BITS'(cfg.frame_height);
      default:          prdata = '0;
    endcase
  end

  ckct_front #(
    .COORD_BITS (COORD_BITS),
    .SUM_BITS   (SUM_BITS),
    .JOB_BITS   (JOB_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .frame_end (frame_end),
    .job_valid (job_valid),
    .job_data  (job_wr_data)
  );

  ckct_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (JOB_DEPTH)
  ) u_jobs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_data (job_wr_data),
    .rd_en   (job_pop),
    .rd_data (job_rd_data),
    .full    (full),
    .empty   (job_empty)
  );

  ckct_back #(
    .COORD_BITS (COORD_BITS),
    .SUM_BITS   (SUM_BITS),
    .JOB_BITS   (JOB_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_empty   (job_empty),
    .job_data    (job_rd_data),
    .job_pop     (job_pop),
    .pop         (pop),
    .empty       (empty),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .match_count (match_count),
    .empty_frame (empty_frame)
  );

endmodule

// File: hw/rtl/ckct_queue.sv
// Small register queue that parts the pixel front from the divider back.
// Depends on nothing but its parameters.
module ckct_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] used;
  logic                do_wr;
  logic                do_rd;

  assign full    = (used == CNT_BITS'(DEPTH));
  assign empty   = (used == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        used <= used + CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
        used <= used - CNT_BITS'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ckct_front.sv
// Pixel front: classify each beat and accumulate column, row and count.
// Depends on ckct_pkg; emits one frame job per frame end.
module ckct_front #(
  parameter int COORD_BITS = ckct_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS   = ckct_pkg::COUNT_BITS + COORD_BITS,
  parameter int JOB_BITS   = ckct_pkg::COUNT_BITS + 2 * SUM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ckct_pkg::cfg_t        cfg,
  input  logic                  accept,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [7:0]            blue,
  input  logic [7:0]            green,
  input  logic [7:0]            red,
  input  logic                  frame_end,
  output logic                  job_valid,
  output logic [JOB_BITS-1:0]   job_data
);
  import ckct_pkg::*;

  localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

  logic [SUM_BITS-1:0]   sum_x;
  logic [SUM_BITS-1:0]   sum_y;
  logic [COUNT_BITS-1:0] count;
  logic [SUM_BITS-1:0]   sum_x_next;
  logic [SUM_BITS-1:0]   sum_y_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  interior;
  logic                  hit;

  always_comb begin
    interior = (pixel_x != '0) && (pixel_y != '0) &&
               ((CMP_BITS'(pixel_x) + CMP_BITS'(1)) < CMP_BITS'(cfg.frame_width)) &&
               ((CMP_BITS'(pixel_y) + CMP_BITS'(1)) < CMP_BITS'(cfg.frame_height));
    hit = interior && (count != COUNT_MAX) &&
          chan_close(blue, cfg.ref_blue, cfg.tolerance) &&
          chan_close(green, cfg.ref_green, cfg.tolerance) &&
          chan_close(red, cfg.ref_red, cfg.tolerance);
    sum_x_next = hit ? sum_x + SUM_BITS'(pixel_x) : sum_x;
    sum_y_next = hit ? sum_y + SUM_BITS'(pixel_y) : sum_y;
    count_next = hit ? count + COUNT_BITS'(1) : count;
  end

  assign job_valid = accept && frame_end;
  assign job_data  = {count_next, sum_y_next, sum_x_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        sum_x <= '0;
        sum_y <= '0;
        count <= '0;
      end else begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        count <= count_next;
      end
    end
  end

endmodule

// File: hw/rtl/ckct_back.sv
// Divider back: restoring division of both sums by the count, one
// quotient bit per cycle, into a result register. Depends on ckct_pkg.
module ckct_back #(
  parameter int COORD_BITS = ckct_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS   = ckct_pkg::COUNT_BITS + COORD_BITS,
  parameter int JOB_BITS   = ckct_pkg::COUNT_BITS + 2 * SUM_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_empty,
  input  logic [JOB_BITS-1:0]             job_data,
  output logic                            job_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic [COORD_BITS-1:0]           centroid_x,
  output logic [COORD_BITS-1:0]           centroid_y,
  output logic [ckct_pkg::COUNT_BITS-1:0] match_count,
  output logic                            empty_frame
);
  import ckct_pkg::*;

  localparam int STEP_BITS = $clog2(COORD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t           state;
  logic [SUM_BITS-1:0]   rem_x;
  logic [SUM_BITS-1:0]   rem_y;
  logic [SUM_BITS-1:0]   divisor;
  logic [COUNT_BITS-1:0] count;
  logic [COORD_BITS-1:0] quo_x;
  logic [COORD_BITS-1:0] quo_y;
  logic [STEP_BITS-1:0]  step;
  logic                  out_valid;
  logic                  ge_x;
  logic                  ge_y;
  logic                  load_out;

  assign ge_x     = (rem_x >= divisor);
  assign ge_y     = (rem_y >= divisor);
  assign job_pop  = (state == ST_IDLE) && !job_empty;
  assign load_out = (state == ST_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= ST_DIV;
            step  <= STEP_BITS'(COORD_BITS - 1);
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_DONE;
          end else begin
            step <= step - STEP_BITS'(1);
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      rem_x   <= job_data[SUM_BITS-1:0];
      rem_y   <= job_data[2*SUM_BITS-1:SUM_BITS];
      count   <= job_data[JOB_BITS-1:2*SUM_BITS];
      divisor <= SUM_BITS'(job_data[JOB_BITS-1:2*SUM_BITS]) << (COORD_BITS - 1);
    end else if (state == ST_DIV) begin
      rem_x   <= ge_x ? rem_x - divisor : rem_x;
      rem_y   <= ge_y ? rem_y - divisor : rem_y;
      quo_x   <= {quo_x[COORD_BITS-2:0], ge_x};
      quo_y   <= {quo_y[COORD_BITS-2:0], ge_y};
      divisor <= divisor >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      empty_frame <= (count == '0);
      match_count <= count;
      centroid_x  <= (count == '0) ? '0 : quo_x;
      centroid_y  <= (count == '0) ? '0 : quo_y;
    end
  end

endmodule

// File: hw/rtl/ckct_checker.sv
// Port-level checks of the color-key centroid tracker, bound to its top.
// Depends on ckct_pkg and color_key_centroid_tracker.
module ckct_checker #(
  parameter int COORD_BITS = ckct_pkg::COORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            pop,
  input logic                            empty,
  input logic [COORD_BITS-1:0]           centroid_x,
  input logic [COORD_BITS-1:0]           centroid_y,
  input logic [ckct_pkg::COUNT_BITS-1:0] match_count,
  input logic                            empty_frame
);
  import ckct_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(centroid_x) && $stable(centroid_y) &&
                       $stable(match_count) && $stable(empty_frame))
    else $error("stalled result beat changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && empty_frame |-> centroid_x == '0 && centroid_y == '0 && match_count == '0)
    else $error("empty frame with nonzero fields");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty && !empty_frame |-> match_count != '0)
    else $error("matched frame with zero count");

endmodule

bind color_key_centroid_tracker ckct_checker #(.COORD_BITS(COORD_BITS)) u_ckct_checker (.*);

// File: tb/testbench.sv
// Testbench of color_key_centroid_tracker: drives pixels, register writes and result pops.
// Holds a scoreboard class that predicts each frame's centroid; depends on ckct_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import ckct_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int SETTLE = 2 * (CB + 3) + 4;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    blue;
    logic [7:0]    green;
    logic [7:0]    red;
    logic          frame_end;
  } pixel_t;

  typedef struct {
    logic [CB-1:0]         cx;
    logic [CB-1:0]         cy;
    logic [COUNT_BITS-1:0] count;
    logic                  empty;
  } centroid_t;

  class centroid_scoreboard;
    logic [7:0]            ref_b, ref_g, ref_r, tol;
    logic [11:0]           width, height;
    longint                sum_x, sum_y;
    logic [COUNT_BITS-1:0] hits;
    centroid_t             frames_q[$];
    int                    mismatches, pixels, results;

    function new();
      ref_b = RESET_REF_BLUE;
      ref_g = RESET_REF_GREEN;
      ref_r = RESET_REF_RED;
      tol = RESET_TOLERANCE;
      width = RESET_FRAME_WIDTH;
      height = RESET_FRAME_HEIGHT;
      sum_x = 0;
      sum_y = 0;
      hits = '0;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_REF_BLUE:     ref_b = v[7:0];
        REG_REF_GREEN:    ref_g = v[7:0];
        REG_REF_RED:      ref_r = v[7:0];
        REG_TOLERANCE:    tol = v[7:0];
        REG_FRAME_WIDTH:  width = v[11:0];
        REG_FRAME_HEIGHT: height = v[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(reg_index_t idx);
      case (idx)
        REG_REF_BLUE:     return {24'd0, ref_b};
        REG_REF_GREEN:    return {24'd0, ref_g};
        REG_REF_RED:      return {24'd0, ref_r};
        REG_TOLERANCE:    return {24'd0, tol};
        REG_FRAME_WIDTH:  return {20'd0, width};
        REG_FRAME_HEIGHT: return {20'd0, height};
        default:          return '0;
      endcase
    endfunction

    function bit level_near(logic [7:0] level, logic [7:0] refl);
      int d;
      d = (level >= refl) ? int'(level) - int'(refl) : int'(refl) - int'(level);
      return d < int'(tol);
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void note_pixel(pixel_t p);
      bit        in_frame;
      centroid_t want;
      pixels++;
      in_frame = int'(p.x) >= 1 && int'(p.x) + 1 < int'(width) &&
                 int'(p.y) >= 1 && int'(p.y) + 1 < int'(height);
      if (in_frame && level_near(p.blue, ref_b) && level_near(p.green, ref_g) &&
          level_near(p.red, ref_r) && hits < COUNT_MAX) begin
        sum_x += p.x;
        sum_y += p.y;
        hits++;
      end
      if (!p.frame_end)
        return;
      if (hits == 0) begin
        want.cx = '0;
        want.cy = '0;
        want.count = '0;
        want.empty = 1'b1;
      end else begin
        want.cx = CB'(sum_x / longint'(hits));
        want.cy = CB'(sum_y / longint'(hits));
        want.count = hits;
        want.empty = 1'b0;
      end
      frames_q.push_back(want);
      sum_x = 0;
      sum_y = 0;
      hits = '0;
    endfunction

    function void check_result(centroid_t got);
      centroid_t want;
      results++;
      if (frames_q.size() == 0) begin
        flag("result beat with no frame pending (match_count)", -1, got.count);
        return;
      end
      want = frames_q.pop_front();
      if (got.cx !== want.cx) flag("centroid_x", want.cx, got.cx);
      if (got.cy !== want.cy) flag("centroid_y", want.cy, got.cy);
      if (got.count !== want.count) flag("match_count", want.count, got.count);
      if (got.empty !== want.empty) flag("empty_frame", want.empty, got.empty);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [CB-1:0]         pixel_x = '0;
  logic [CB-1:0]         pixel_y = '0;
  logic [7:0]            blue = '0;
  logic [7:0]            green = '0;
  logic [7:0]            red = '0;
  logic                  frame_end = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [CB-1:0]         centroid_x;
  logic [CB-1:0]         centroid_y;
  logic [COUNT_BITS-1:0] match_count;
  logic                  empty_frame;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  centroid_scoreboard sb = new();
  bit  steady = 1'b0;
  int  cycles = 0;
  int  settings = 0;

  color_key_centroid_tracker #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .blue(blue), .green(green), .red(red), .frame_end(frame_end),
    .empty(empty), .pop(pop),
    .centroid_x(centroid_x), .centroid_y(centroid_y),
    .match_count(match_count), .empty_frame(empty_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    centroid_t got;
    forever begin
      @(negedge clk);
      pop = steady || ($urandom_range(0, 99) >= 38);
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.cx = centroid_x;
        got.cy = centroid_y;
        got.count = match_count;
        got.empty = empty_frame;
        sb.check_result(got);
      end
    end
  end

  task automatic send_pixel(input pixel_t p);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 38) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    pixel_x = p.x;
    pixel_y = p.y;
    blue = p.blue;
    green = p.green;
    red = p.red;
    frame_end = p.frame_end;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (sb.frames_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] val);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_BITS'(int'(idx) * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    sb.set_register(idx, val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== sb.register_value(idx))
      sb.flag("register readback", sb.register_value(idx), got);
  endtask

  function automatic pixel_t mk(int x, int y, int b, int g, int r, bit fe);
    pixel_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    p.blue = 8'(b);
    p.green = 8'(g);
    p.red = 8'(r);
    p.frame_end = fe;
    return p;
  endfunction

  function automatic int chan_level(logic [7:0] refl);
    int v;
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 255);
    v = int'($urandom_range(0, int'(sb.tol) + 1));
    v = $urandom_range(0, 1) ? int'(refl) + v : int'(refl) - v;
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  function automatic pixel_t near_pixel(int x, int y, bit fe);
    return mk(x, y, chan_level(sb.ref_b), chan_level(sb.ref_g), chan_level(sb.ref_r), fe);
  endfunction

  function automatic int edge_coord(int dim);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return dim - 2;
      3:       return dim - 1;
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic run_phase(input int rb, input int rg, input int rr, input int tl,
                           input int fw, input int fh, input int n);
    int     done;
    int     k;
    int     cut;
    int     area;
    pixel_t p;
    write_register(REG_REF_BLUE, rb);
    write_register(REG_REF_GREEN, rg);
    write_register(REG_REF_RED, rr);
    write_register(REG_TOLERANCE, tl);
    write_register(REG_FRAME_WIDTH, fw);
    write_register(REG_FRAME_HEIGHT, fh);
    settings++;
    area = fw * fh;
    done = 0;
    while (done < n) begin
      if (area > 400) begin
        send_pixel(near_pixel(edge_coord(fw), edge_coord(fh), $urandom_range(0, 9) == 0));
        done++;
      end else if ($urandom_range(0, 9) == 0) begin
        p = mk($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3) == 0);
        send_pixel(p);
        done++;
      end else begin
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, area - 1) : area - 1;
        for (k = 0; k <= cut; k++)
          send_pixel(near_pixel(k % fw, k / fw, k == cut));
        done += cut + 1;
      end
    end
    send_pixel(near_pixel(1, 1, 1'b1));
    drain();
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pixel(mk(1, 1, 65, 70, 170, 0));
    send_pixel(mk(638, 478, 65, 70, 170, 0));
    send_pixel(mk(0, 5, 65, 70, 170, 0));
    send_pixel(mk(639, 5, 65, 70, 170, 0));
    send_pixel(mk(5, 0, 65, 70, 170, 0));
    send_pixel(mk(5, 479, 65, 70, 170, 0));
    send_pixel(mk(2047, 2047, 65, 70, 170, 0));
    send_pixel(mk(10, 10, 94, 70, 170, 0));
    send_pixel(mk(10, 10, 95, 70, 170, 0));
    send_pixel(mk(10, 10, 36, 70, 170, 0));
    send_pixel(mk(10, 10, 35, 70, 170, 0));
    send_pixel(mk(10, 10, 65, 99, 170, 0));
    send_pixel(mk(10, 10, 65, 100, 170, 0));
    send_pixel(mk(10, 10, 65, 70, 199, 0));
    send_pixel(mk(10, 10, 65, 70, 200, 0));
    send_pixel(mk(10, 10, 65, 70, 141, 0));
    send_pixel(mk(10, 10, 65, 70, 140, 0));
    send_pixel(mk(3, 4, 0, 0, 0, 0));
    send_pixel(mk(3, 4, 255, 255, 255, 0));
    send_pixel(mk(20, 30, 65, 70, 170, 1));
    send_pixel(mk(5, 5, 0, 0, 0, 1));
    send_pixel(mk(0, 0, 65, 70, 170, 1));
    drain();

    run_phase(GREY_REF_LEVEL, GREY_REF_LEVEL, GREY_REF_LEVEL, 30, 8, 6, 150);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              0, 5, 4, 100);
    run_phase(0, 0, 0, 255, 3, 3, 100);
    run_phase(255, 255, 255, 255, 6, 5, 100);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              1, 4, 7, 100);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(1, 255), 2048, 2048, 150);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(1, 255), 2048, 3, 100);
    for (i = 0; i < 6; i++) begin
      steady = (i == 2);
      run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(1, 255), $urandom_range(3, 14), $urandom_range(3, 14), 120);
    end
    steady = 1'b0;
    drain();

    $display("Streamed %0d pixels under %0d register settings plus reset values;",
             sb.pixels, settings);
    $display("checked %0d frame results, %0d mismatches.", sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.frames_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
